// ----- rtl/core/rtmc_pkg.sv -----
// shared types and constants for the rotated template match counter
// no dependencies; imported by every module of the core
package rtmc_pkg;

    localparam int MAX_GRID_DEF    = 64;
    localparam int MAX_PATTERN_DEF = 16;

    localparam int GRID_SIZE_W    = 7;
    localparam int PATTERN_SIZE_W = 5;
    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = 7;

    localparam int OP_W        = 2;
    localparam int ROWCOL_W    = 6;
    localparam int CELL_W      = 8;
    localparam int IN_DATA_W   = 24;

    localparam int COUNT_W     = 13;
    localparam int OUT_DATA_W  = 56;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_SIZE    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_SIZE = 1'd1;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_GRID = 2'd0,
        OP_WRITE_PAT  = 2'd1,
        OP_RUN        = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_SEND
    } ctl_state_t;

    typedef struct packed {
        logic write_grid;
        logic write_pat;
        logic start;
        logic issue;
    } dp_cmd_t;

    typedef struct packed {
        logic skip;
        logic last_issue;
    } dp_status_t;

endpackage

// ----- rtl/core/rtmc_ctrl.sv -----
// run controller: input handshake, scan sequencing and result hand-off
// depends on rtmc_pkg
module rtmc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [rtmc_pkg::OP_W-1:0] in_op,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rtmc_pkg::dp_cmd_t    cmd,
    input  rtmc_pkg::dp_status_t status
);
    import rtmc_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       take;

    assign take = in_valid && (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take && in_op == OP_RUN)
                begin
                    state_next = status.skip ? S_SEND : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (status.last_issue)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                state_next = S_SEND;
            end
            S_SEND:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.write_grid = take && in_op == OP_WRITE_GRID;
                cmd.write_pat  = take && in_op == OP_WRITE_PAT;
                cmd.start      = take && in_op == OP_RUN;
            end
            S_SCAN:
            begin
                cmd.issue = 1'b1;
            end
            S_FLUSH:
            begin
                cmd = '0;
            end
            S_SEND:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/core/rtmc_datapath.sv -----
// stores, size registers, placement counters, compare stage and match counts
// depends on rtmc_pkg
module rtmc_datapath #(
    parameter int MAX_GRID    = rtmc_pkg::MAX_GRID_DEF,
    parameter int MAX_PATTERN = rtmc_pkg::MAX_PATTERN_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rtmc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rtmc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [rtmc_pkg::ROWCOL_W-1:0]       row,
    input  logic [rtmc_pkg::ROWCOL_W-1:0]       col,
    input  logic [rtmc_pkg::CELL_W-1:0]         cell_req,
    input  rtmc_pkg::dp_cmd_t                   cmd,
    output rtmc_pkg::dp_status_t                status,
    output logic [rtmc_pkg::COUNT_W-1:0]        count_rot0,
    output logic [rtmc_pkg::COUNT_W-1:0]        count_rot90,
    output logic [rtmc_pkg::COUNT_W-1:0]        count_rot180,
    output logic [rtmc_pkg::COUNT_W-1:0]        count_rot270
);
    import rtmc_pkg::*;

    localparam int IW = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
    localparam int KW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int NW = $clog2(MAX_GRID + 1);
    localparam int MW = $clog2(MAX_PATTERN + 1);
    localparam int GD = MAX_GRID * MAX_GRID;
    localparam int PD = MAX_PATTERN * MAX_PATTERN;
    localparam int GA = (GD > 1) ? $clog2(GD) : 1;
    localparam int PA = (PD > 1) ? $clog2(PD) : 1;

    logic [CELL_W-1:0] grid_mem [GD];
    logic [CELL_W-1:0] pat_mem  [PD];

    logic [GRID_SIZE_W-1:0]    grid_size_reg;
    logic [PATTERN_SIZE_W-1:0] pattern_size_reg;

    logic [NW-1:0] n_eff;
    logic [MW-1:0] m_eff;
    logic [IW-1:0] lim;
    logic [KW-1:0] mlast;

    logic [IW-1:0] i_reg, j_reg;
    logic [KW-1:0] k_reg, t_reg;
    logic [1:0]    rot_reg;
    logic          t_end, k_end, j_end, i_end;

    logic [KW-1:0] pr, pc;
    logic [GA-1:0] g_raddr, g_waddr;
    logic [PA-1:0] p_raddr, p_waddr;
    logic          g_wok, p_wok;

    logic [CELL_W-1:0] g_q_reg, p_q_reg;
    logic              tag_v_reg, tag_first_reg, tag_last_reg;
    logic [1:0]        tag_rot_reg;
    logic              same_reg;
    logic              same_now;
    logic [COUNT_W-1:0] cnt_reg [4];

    // effective sizes, clamped to the store dimensions
    assign n_eff = (int'(grid_size_reg) > MAX_GRID) ? NW'(MAX_GRID) : NW'(grid_size_reg);
    assign m_eff = (int'(pattern_size_reg) > MAX_PATTERN) ? MW'(MAX_PATTERN)
                                                            : MW'(pattern_size_reg);
    assign status.skip = (n_eff == '0) || (m_eff == '0) || (int'(m_eff) > int'(n_eff));
    assign lim   = IW'(int'(n_eff) - int'(m_eff));
    assign mlast = KW'(int'(m_eff) - 1);

    assign t_end = (t_reg == mlast);
    assign k_end = (k_reg == mlast);
    assign j_end = (j_reg == lim);
    assign i_end = (i_reg == lim);
    assign status.last_issue = t_end && k_end && (rot_reg == ROT_270) && j_end && i_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg    <= GRID_SIZE_W'(64);
            pattern_size_reg <= PATTERN_SIZE_W'(16);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_GRID_SIZE)
            begin
                grid_size_reg <= cfg_data[GRID_SIZE_W-1:0];
            end
            if (cfg_index == CFG_PATTERN_SIZE)
            begin
                pattern_size_reg <= cfg_data[PATTERN_SIZE_W-1:0];
            end
        end
    end

    // placement walk: cell column fastest, then cell row, rotation, column, row
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            i_reg   <= '0;
            j_reg   <= '0;
            k_reg   <= '0;
            t_reg   <= '0;
            rot_reg <= ROT_0;
        end
        else if (cmd.issue)
        begin
            t_reg <= t_end ? '0 : t_reg + 1'b1;
            if (t_end)
            begin
                k_reg <= k_end ? '0 : k_reg + 1'b1;
                if (k_end)
                begin
                    rot_reg <= rot_reg + 2'd1;
                    if (rot_reg == ROT_270)
                    begin
                        j_reg <= j_end ? '0 : j_reg + 1'b1;
                        if (j_end)
                        begin
                            i_reg <= i_reg + 1'b1;
                        end
                    end
                end
            end
        end
    end

    // rotation as an index remap into the one pattern store
    always_comb
    begin
        case (rot_reg)
            ROT_0:   begin pr = k_reg;         pc = t_reg;         end
            ROT_90:  begin pr = mlast - t_reg; pc = k_reg;         end
            ROT_180: begin pr = mlast - k_reg; pc = mlast - t_reg; end
            ROT_270: begin pr = t_reg;         pc = mlast - k_reg; end
            default: begin pr = k_reg;         pc = t_reg;         end
        endcase
    end

    assign g_raddr = GA'((int'(i_reg) + int'(k_reg)) * MAX_GRID + int'(j_reg) + int'(t_reg));
    assign p_raddr = PA'(int'(pr) * MAX_PATTERN + int'(pc));
    assign g_waddr = GA'(int'(row) * MAX_GRID + int'(col));
    assign p_waddr = PA'(int'(row) * MAX_PATTERN + int'(col));
    assign g_wok   = (int'(row) < MAX_GRID) && (int'(col) < MAX_GRID);
    assign p_wok   = (int'(row) < MAX_PATTERN) && (int'(col) < MAX_PATTERN);

    always_ff @(posedge clk)
    begin
        if (cmd.write_grid && g_wok)
        begin
            grid_mem[g_waddr] <= cell_req;
        end
        g_q_reg <= grid_mem[g_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_pat && p_wok)
        begin
            pat_mem[p_waddr] <= cell_req;
        end
        p_q_reg <= pat_mem[p_raddr];
    end

    // compare stage runs in the cycle after the address stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_v_reg <= 1'b0;
        end
        else
        begin
            tag_v_reg <= cmd.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_first_reg <= (k_reg == '0) && (t_reg == '0);
        tag_last_reg  <= t_end && k_end;
        tag_rot_reg   <= rot_reg;
    end

    assign same_now = (tag_first_reg || same_reg) && (g_q_reg == p_q_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            same_reg <= 1'b0;
            for (int q = 0; q < 4; q++)
            begin
                cnt_reg[q] <= '0;
            end
        end
        else if (cmd.start)
        begin
            for (int q = 0; q < 4; q++)
            begin
                cnt_reg[q] <= '0;
            end
        end
        else if (tag_v_reg)
        begin
            same_reg <= same_now;
            if (tag_last_reg && same_now && cnt_reg[tag_rot_reg] != COUNT_MAX)
            begin
                cnt_reg[tag_rot_reg] <= cnt_reg[tag_rot_reg] + 1'b1;
            end
        end
    end

    assign count_rot0   = cnt_reg[ROT_0];
    assign count_rot90  = cnt_reg[ROT_90];
    assign count_rot180 = cnt_reg[ROT_180];
    assign count_rot270 = cnt_reg[ROT_270];

endmodule

// ----- rtl/core/rotated_template_match_counter_core.sv -----
// top level of the rotated template match counter
// depends on rtmc_pkg, rtmc_ctrl and rtmc_datapath
//
// usage: cells are loaded over the s_ channel, one transfer per cell, with
// op selecting grid or pattern store; each load gives no
// result. a transfer with the run op walks every placement of the pattern
// inside the grid and returns one transfer on the m_ channel with the four
// rotation match counts. the cfg_ channel sets grid and pattern side lengths
// and is always ready; write it only while idle.
// run sequence: after the run transfer the scan compares one pattern cell per
// cycle through a single read port on each store, then a compare flush state
// precedes the result; a run with an empty grid or an empty or oversize
// pattern skips the scan and can transfer in the cycle after the run transfer.
// only one item is handled at a time: s_tready is low from a run until its
// result is taken, so a stalled receiver holds the result and blocks input.
// reset clears control and counts and sets sizes to 64 and 16; stores are
// not cleared and must be written before use.
module rotated_template_match_counter_core #(
    parameter int MAX_GRID    = rtmc_pkg::MAX_GRID_DEF,
    parameter int MAX_PATTERN = rtmc_pkg::MAX_PATTERN_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // op[1:0], row[7:2], col[13:8], cell_req[21:14], zero pad
    input  logic [rtmc_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // count_rot0[12:0], count_rot90[25:13], count_rot180[38:26],
    // count_rot270[51:39], zero pad
    output logic [rtmc_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rtmc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rtmc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import rtmc_pkg::*;

    dp_cmd_t            cmd;
    dp_status_t         status;
    logic [COUNT_W-1:0] c0, c90, c180, c270;

    assign cfg_ready = 1'b1;

    rtmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tdata[OP_W-1:0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .status    (status)
    );

    rtmc_datapath #(
        .MAX_GRID    (MAX_GRID),
        .MAX_PATTERN (MAX_PATTERN)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .row          (s_tdata[7:2]),
        .col          (s_tdata[13:8]),
        .cell_req     (s_tdata[21:14]),
        .cmd          (cmd),
        .status       (status),
        .count_rot0   (c0),
        .count_rot90  (c90),
        .count_rot180 (c180),
        .count_rot270 (c270)
    );

    assign m_tdata = {4'b0, c270, c180, c90, c0};

endmodule
